// ===== design/cfsd_pkg.sv =====
`default_nettype none

package cfsd_pkg;

   localparam int CARD_W = 48;
   localparam int TICK_W = 16;

   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [7:0] CODE_LOW    = 8'h30;
   localparam logic [7:0] CODE_HIGH   = 8'h33;

   localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd1500;
   localparam logic [TICK_W-1:0] TICKS_MAX    = 16'hFFFF;

   // register select on paddr[2]
   localparam logic REG_WINDOW = 1'b0;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_CODE = 2'd1,
      PH_CARD = 2'd2
   } phase_type;

   typedef struct packed {
      logic tick;
      logic card_done;
   } frame_event_type;

endpackage

`default_nettype wire

// ===== design/card_frame_sync_dedup_unit.sv =====
`default_nettype none

// Channel  | Direction | Ports                                   | Moves
// req      | in        | req_valid/req_ready, mode, data_byte    | one byte or tick request
// rsp      | out       | rsp_valid/rsp_ready, card_number        | one reported card
// csr      | in/out    | APB psel/penable/pwrite/paddr/pwdata    | dedup window register
//
// One request per cycle unless rsp stalls; a card reaches rsp after its last byte request.
// Input register feeds the framer/dedup logic, which loads the result register.
// A stalled rsp holds the pipeline; an empty input register still takes one more request.
// Synchronous reset clears framing, dedup history and the window (to 1500).

module card_frame_sync_dedup_unit #(
   parameter int FRAME_BYTES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic [7:0]                    req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cfsd_pkg::CARD_W-1:0]        rsp_card_number,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic                          in_valid_ff;
   logic                          in_mode_ff;
   logic [7:0]                    in_byte_ff;
   logic                          rsp_valid_ff;
   logic [cfsd_pkg::CARD_W-1:0]   rsp_card_ff;
   logic [cfsd_pkg::TICK_W-1:0]   window_ff;
   logic                          advance;
   logic                          step;
   logic                          report;
   logic                          csr_write;
   cfsd_pkg::frame_event_type     frame_event;
   logic [cfsd_pkg::CARD_W-1:0]   card;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_data_byte;
      end
   end

   cfsd_framer #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .mode      (in_mode_ff),
      .data_byte (in_byte_ff),
      .event_out (frame_event),
      .card_out  (card)
   );

   cfsd_dedup u_dedup (
      .clock    (clock),
      .reset    (reset),
      .event_in (frame_event),
      .card_in  (card),
      .window   (window_ff),
      .report   (report)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= report;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && report) begin
         rsp_card_ff <= card;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_number = rsp_card_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= cfsd_pkg::WINDOW_RESET;
      end else if (csr_write && csr_paddr[2] == cfsd_pkg::REG_WINDOW) begin
         window_ff <= csr_pwdata[cfsd_pkg::TICK_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == cfsd_pkg::REG_WINDOW) begin
         csr_prdata = {16'd0, window_ff};
      end
   end

endmodule

`default_nettype wire

// ===== design/cfsd_framer.sv =====
`default_nettype none

module cfsd_framer #(
   parameter int FRAME_BYTES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          mode,
   input  wire logic [7:0]                    data_byte,
   output cfsd_pkg::frame_event_type          event_out,
   output logic [cfsd_pkg::CARD_W-1:0]        card_out
);

   localparam logic [2:0] CARD_BYTES = 3'(FRAME_BYTES - 2);

   cfsd_pkg::phase_type            phase_ff, phase_in;
   logic [2:0]                     count_ff, count_in;
   logic [cfsd_pkg::CARD_W-1:0]    shift_ff, shift_in;
   logic                           is_byte;
   logic                           code_ok;
   logic [2:0]                     count_inc;
   logic                           last_byte;

   assign is_byte   = (mode == cfsd_pkg::MODE_BYTE);
   assign code_ok   = (data_byte >= cfsd_pkg::CODE_LOW) && (data_byte <= cfsd_pkg::CODE_HIGH);
   assign count_inc = count_ff + 3'd1;
   assign last_byte = !(count_inc < CARD_BYTES);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step && is_byte) begin
         case (phase_ff)
            cfsd_pkg::PH_CODE: begin
               if (data_byte == cfsd_pkg::HEADER_BYTE) begin
                  phase_in = cfsd_pkg::PH_CODE;
               end else if (code_ok) begin
                  phase_in = cfsd_pkg::PH_CARD;
               end else begin
                  phase_in = cfsd_pkg::PH_HUNT;
               end
            end
            cfsd_pkg::PH_CARD: begin
               if (last_byte) begin
                  phase_in = cfsd_pkg::PH_HUNT;
               end
            end
            default: begin
               // unused code behaves as hunting
               if (data_byte == cfsd_pkg::HEADER_BYTE) begin
                  phase_in = cfsd_pkg::PH_CODE;
               end else begin
                  phase_in = cfsd_pkg::PH_HUNT;
               end
            end
         endcase
      end
   end

   // outputs and card datapath
   always_comb begin
      count_in            = count_ff;
      shift_in            = shift_ff;
      event_out.tick      = step && !is_byte;
      event_out.card_done = 1'b0;
      if (step && is_byte) begin
         case (phase_ff)
            cfsd_pkg::PH_CODE: begin
               if (data_byte != cfsd_pkg::HEADER_BYTE && code_ok) begin
                  count_in = '0;
                  shift_in = '0;
               end
            end
            cfsd_pkg::PH_CARD: begin
               shift_in = {shift_ff[cfsd_pkg::CARD_W-9:0], data_byte};
               if (last_byte) begin
                  count_in            = '0;
                  event_out.card_done = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   assign card_out = shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfsd_pkg::PH_HUNT;
         count_ff <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cfsd_dedup.sv =====
`default_nettype none

module cfsd_dedup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfsd_pkg::frame_event_type     event_in,
   input  wire logic [cfsd_pkg::CARD_W-1:0]   card_in,
   input  wire logic [cfsd_pkg::TICK_W-1:0]   window,
   output logic                               report
);

   logic [cfsd_pkg::CARD_W-1:0]  last_card_ff, last_card_in;
   logic                         last_valid_ff, last_valid_in;
   logic [cfsd_pkg::TICK_W-1:0]  elapsed_ff, elapsed_in;
   logic                         suppress;

   assign suppress = last_valid_ff && (card_in == last_card_ff) && (elapsed_ff < window);
   assign report   = event_in.card_done && !suppress;

   always_comb begin
      last_card_in  = last_card_ff;
      last_valid_in = last_valid_ff;
      elapsed_in    = elapsed_ff;
      if (report) begin
         last_card_in  = card_in;
         last_valid_in = 1'b1;
         elapsed_in    = '0;
      end else if (event_in.tick && elapsed_ff != cfsd_pkg::TICKS_MAX) begin
         elapsed_in = elapsed_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_card_ff  <= '0;
         last_valid_ff <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         last_card_ff  <= last_card_in;
         last_valid_ff <= last_valid_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cfsd_checker.sv =====
`default_nettype none

module cfsd_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          req_mode,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [cfsd_pkg::CARD_W-1:0]   rsp_card_number,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   input  wire logic [31:0]                   csr_prdata,
   input  wire logic                          csr_pready
);

   // a held card stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_card_number))
      else $error("rsp card changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a fresh card comes from a byte request that passed the input and result registers, which is its low byte
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_mode == cfsd_pkg::MODE_BYTE, 2)
         && rsp_card_number[7:0] == $past(req_data_byte, 2))
      else $error("card not tied to a byte request");

   a_window_read: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_paddr[2] == cfsd_pkg::REG_WINDOW |-> csr_prdata[31:16] == 16'd0)
      else $error("window readback upper bits set");

   a_window_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[2] == cfsd_pkg::REG_WINDOW
      |=> csr_prdata[15:0] == $past(csr_pwdata[15:0]) || csr_paddr[2] != cfsd_pkg::REG_WINDOW)
      else $error("window write not visible");

endmodule

bind card_frame_sync_dedup_unit cfsd_checker u_cfsd_checker (.*);

`default_nettype wire
